// ===== hdl/rqr_pkg.sv =====
// shared constants and types for the ready queue with remove by id
package rqr_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int HND_W = 16;
  localparam int ID_W  = 16;
  localparam int FUNC_W = 2;
  localparam int STAT_W = 2;
  localparam int OUT_CNT_W = 5;

  localparam logic [FUNC_W-1:0] FUNC_ENQ = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEQ = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REM = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

  typedef struct packed {
    logic             deq;
    logic             rem;
    logic [HND_W-1:0] hnd;
    logic [ID_W-1:0]  id;
  } cell_cmd_t;

endpackage

// ===== hdl/rqr_cell.sv =====
// one queue slot: holds an entry, compares its id and shifts toward the head
module rqr_cell (
  input  logic                      clk_i,
  input  rqr_pkg::cell_cmd_t        cmd_i,
  input  logic                      live_i,
  input  logic                      load_i,
  input  logic [rqr_pkg::HND_W-1:0] nxt_handle_i,
  input  logic [rqr_pkg::ID_W-1:0]  nxt_id_i,
  input  logic                      match_i,
  input  logic [rqr_pkg::HND_W-1:0] hout_i,
  output logic [rqr_pkg::HND_W-1:0] handle_o,
  output logic [rqr_pkg::ID_W-1:0]  id_o,
  output logic                      match_o,
  output logic [rqr_pkg::HND_W-1:0] hout_o
);

  logic [rqr_pkg::HND_W-1:0] handle_q, handle_d;
  logic [rqr_pkg::ID_W-1:0]  id_q, id_d;
  logic                      hit;
  logic                      first;
  logic                      shift;

  always_comb begin
    hit     = cmd_i.rem && live_i && (id_q == cmd_i.id);
    first   = hit && !match_i;
    match_o = match_i || hit;
    hout_o  = first ? handle_q : hout_i;
    shift   = cmd_i.deq || (cmd_i.rem && match_o);
    handle_d = handle_q;
    id_d     = id_q;
    if (shift) begin
      handle_d = nxt_handle_i;
      id_d     = nxt_id_i;
    end else if (load_i) begin
      handle_d = cmd_i.hnd;
      id_d     = cmd_i.id;
    end
  end

  always_ff @(posedge clk_i) begin
    handle_q <= handle_d;
    id_q     <= id_d;
  end

  assign handle_o = handle_q;
  assign id_o     = id_q;

endmodule

// ===== hdl/ready_queue_with_remove_by_id.sv =====
// top level of the ready queue: cell row, entry count and output register
//
// A first-in first-out queue of thread entries (handle and id) held in a row
// of identical cells, head in cell 0. One input word carries one operation
// in s_axis_tuser: enqueue, dequeue, or remove the entry nearest the head
// whose id matches; the other entries keep their order. Every input word
// gives exactly one output word with a status in m_axis_tuser and the
// removed handle and the entry count after the operation in m_axis_tdata.
// The id compare runs in every cell at once and a match flag ripples down
// the row, so every cell decides in the same cycle whether to take its
// neighbor's entry. The result is registered and appears in the cycle after
// the input word is accepted, and a new word is accepted every cycle.
// If the receiver stalls, the result waits in the output register and a new
// input word is taken only in a cycle in which that register empties.
// Reset empties the queue and the output register; the slots themselves
// are not cleared, since only slots below the entry count are ever read.
module ready_queue_with_remove_by_id (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // thread_handle[15:0], thread_id[31:16]
  input  logic [1:0]  s_axis_tuser_i,  // func[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // handle_out[15:0], entry_count[20:16], zero[23:21]
  output logic [1:0]  m_axis_tuser_o   // status[1:0]
);

  localparam int DEPTH = rqr_pkg::DEPTH;
  localparam int CNT_W = rqr_pkg::CNT_W;
  localparam int HND_W = rqr_pkg::HND_W;
  localparam int ID_W  = rqr_pkg::ID_W;

  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q, out_valid_d;
  logic [rqr_pkg::STAT_W-1:0] status_q, status_d;
  logic [HND_W-1:0] hout_q, hout_d;

  logic [rqr_pkg::FUNC_W-1:0] func;
  logic             fire;
  logic             full, empty;
  logic             enq_ok, deq_ok, rem_go, found;
  rqr_pkg::cell_cmd_t cmd;

  logic [DEPTH-1:0] live, load;
  logic [HND_W-1:0] cell_handle [DEPTH];
  logic [ID_W-1:0]  cell_id     [DEPTH];
  logic [HND_W-1:0] nxt_handle  [DEPTH];
  logic [ID_W-1:0]  nxt_id      [DEPTH];
  logic [DEPTH:0]   match_chain;
  logic [HND_W-1:0] hout_chain  [DEPTH+1];

  assign func  = s_axis_tuser_i;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign full  = (count_q == CNT_W'(DEPTH));
  assign empty = (count_q == '0);

  assign enq_ok = fire && (func == rqr_pkg::FUNC_ENQ) && !full;
  assign deq_ok = fire && (func == rqr_pkg::FUNC_DEQ) && !empty;
  assign rem_go = fire && (func == rqr_pkg::FUNC_REM);

  always_comb begin
    cmd.deq = deq_ok;
    cmd.rem = rem_go;
    cmd.hnd = s_axis_tdata_i[15:0];
    cmd.id  = s_axis_tdata_i[31:16];
  end

  assign match_chain[0] = 1'b0;
  assign hout_chain[0]  = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign live[i] = (CNT_W'(i) < count_q);
    assign load[i] = enq_ok && (count_q == CNT_W'(i));
    if (i == DEPTH - 1) begin : g_last
      assign nxt_handle[i] = '0;
      assign nxt_id[i]     = '0;
    end else begin : g_mid
      assign nxt_handle[i] = cell_handle[i+1];
      assign nxt_id[i]     = cell_id[i+1];
    end
    rqr_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .live_i      (live[i]),
      .load_i      (load[i]),
      .nxt_handle_i(nxt_handle[i]),
      .nxt_id_i    (nxt_id[i]),
      .match_i     (match_chain[i]),
      .hout_i      (hout_chain[i]),
      .handle_o    (cell_handle[i]),
      .id_o        (cell_id[i]),
      .match_o     (match_chain[i+1]),
      .hout_o      (hout_chain[i+1])
    );
  end

  assign found = match_chain[DEPTH];

  always_comb begin
    count_d     = count_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    hout_d      = hout_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (fire) begin
      out_valid_d = 1'b1;
      status_d    = rqr_pkg::STAT_OK;
      hout_d      = '0;
      case (func)
        rqr_pkg::FUNC_ENQ: begin
          if (full) begin
            status_d = rqr_pkg::STAT_FULL;
          end else begin
            count_d = count_q + 1'b1;
          end
        end
        rqr_pkg::FUNC_DEQ: begin
          if (empty) begin
            status_d = rqr_pkg::STAT_EMPTY;
          end else begin
            hout_d  = cell_handle[0];
            count_d = count_q - 1'b1;
          end
        end
        rqr_pkg::FUNC_REM: begin
          if (found) begin
            hout_d  = hout_chain[DEPTH];
            count_d = count_q - 1'b1;
          end else begin
            status_d = rqr_pkg::STAT_NOTFOUND;
          end
        end
        default: begin
          status_d = rqr_pkg::STAT_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    hout_q   <= hout_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = status_q;
  assign m_axis_tdata_o  = {3'b000, rqr_pkg::OUT_CNT_W'(count_q), hout_q};

`ifndef NO_ASSERTIONS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_enq_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    enq_ok |=> count_q == $past(count_q) + 1'b1)
    else $error("enqueue did not add an entry");

  a_full_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == rqr_pkg::STAT_FULL) |-> full)
    else $error("full reported while queue not full");

  a_handle_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != rqr_pkg::STAT_OK) |-> hout_q == '0)
    else $error("handle given with an error status");

  a_rem_shrinks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_go && found) |=> count_q == $past(count_q) - 1'b1)
    else $error("remove did not take out an entry");
`endif

endmodule

// ===== bench/tb.sv =====
// testbench for the ready queue with remove by id: directed and random words
`timescale 1ns / 100ps

module tb;

  localparam logic [rqr_pkg::FUNC_W-1:0] FUNC_NOP = 2'd3;
  localparam int RANDOM_OPS = 1000;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic [rqr_pkg::FUNC_W-1:0] func;
    logic [rqr_pkg::HND_W-1:0]  hnd;
    logic [rqr_pkg::ID_W-1:0]   id;
    bit                         hold;
  } op_word_t;

  typedef struct {
    logic [rqr_pkg::HND_W-1:0] hnd;
    logic [rqr_pkg::ID_W-1:0]  id;
  } thread_entry_t;

  typedef struct {
    logic [rqr_pkg::STAT_W-1:0]    status;
    logic [rqr_pkg::HND_W-1:0]     hnd;
    logic [rqr_pkg::OUT_CNT_W-1:0] count;
  } op_result_t;

  logic        clk;
  logic        rst_n;
  logic        s_valid = 1'b0;
  logic [31:0] s_data = '0;
  logic [1:0]  s_user = '0;
  logic        s_ready;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [23:0] m_data;
  logic [1:0]  m_user;

  op_word_t      queued_ops[$];
  op_word_t      word_on_bus;
  thread_entry_t held_entries[$];
  op_result_t    awaited_results[$];
  op_result_t    want;

  int total_words = 0;
  int words_sent = 0;
  int results_seen = 0;
  int mismatch_cnt = 0;
  int quiet_cycles = 0;
  bit no_idle;

  ready_queue_with_remove_by_id DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  assign no_idle = (words_sent >= 400) && (words_sent < 600);

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  function automatic void apply_queue_op(input op_word_t w);
    op_result_t r;
    thread_entry_t e;
    int pos;
    r.status = rqr_pkg::STAT_OK;
    r.hnd = '0;
    pos = -1;
    case (w.func)
      rqr_pkg::FUNC_ENQ: begin
        if (held_entries.size() >= rqr_pkg::DEPTH) begin
          r.status = rqr_pkg::STAT_FULL;
        end else begin
          held_entries.push_back('{w.hnd, w.id});
        end
      end
      rqr_pkg::FUNC_DEQ: begin
        if (held_entries.size() == 0) begin
          r.status = rqr_pkg::STAT_EMPTY;
        end else begin
          e = held_entries.pop_front();
          r.hnd = e.hnd;
        end
      end
      rqr_pkg::FUNC_REM: begin
        for (int k = 0; k < held_entries.size(); k++) begin
          if (pos < 0 && held_entries[k].id == w.id) pos = k;
        end
        if (pos < 0) begin
          r.status = rqr_pkg::STAT_NOTFOUND;
        end else begin
          r.hnd = held_entries[pos].hnd;
          held_entries.delete(pos);
        end
      end
      default: ;
    endcase
    r.count = rqr_pkg::OUT_CNT_W'(held_entries.size());
    awaited_results.push_back(r);
  endfunction

  task automatic add_word(input logic [rqr_pkg::FUNC_W-1:0] func,
                          input logic [rqr_pkg::HND_W-1:0] hnd,
                          input logic [rqr_pkg::ID_W-1:0] id);
    queued_ops.push_back('{func, hnd, id, 1'b0});
    total_words++;
  endtask

  task automatic add_pause();
    queued_ops.push_back('{FUNC_NOP, '0, '0, 1'b1});
  endtask

  // driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      s_valid <= 1'b0;
      s_data <= '0;
      s_user <= '0;
      words_sent <= 0;
    end else begin
      if (s_valid && s_ready) begin
        apply_queue_op(word_on_bus);
        words_sent <= words_sent + 1;
      end
      if (!s_valid || s_ready) begin
        if (queued_ops.size() == 0) begin
          s_valid <= 1'b0;
        end else if (queued_ops[0].hold) begin
          if (!(s_valid && s_ready) && words_sent == results_seen) begin
            void'(queued_ops.pop_front());
          end
          s_valid <= 1'b0;
        end else if (!no_idle && $urandom_range(99) < 31) begin
          s_valid <= 1'b0;
        end else begin
          word_on_bus = queued_ops.pop_front();
          s_valid <= 1'b1;
          s_data <= {word_on_bus.id, word_on_bus.hnd};
          s_user <= word_on_bus.func;
        end
      end
    end
  end

  // monitor
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      m_ready <= 1'b0;
      results_seen <= 0;
    end else begin
      if (m_valid && m_ready) begin
        results_seen <= results_seen + 1;
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("unexpected word status %0d data %h", m_user, m_data));
        end else begin
          want = awaited_results.pop_front();
          if (m_user !== want.status || m_data[15:0] !== want.hnd ||
              m_data[20:16] !== want.count || m_data[23:21] !== 3'b000) begin
            report_mismatch($sformatf(
              "status %0d handle %h count %0d pad %b, want status %0d handle %h count %0d",
              m_user, m_data[15:0], m_data[20:16], m_data[23:21],
              want.status, want.hnd, want.count));
          end
        end
      end
      m_ready <= no_idle || ($urandom_range(99) >= 31);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int roll;
    bit fill_phase;
    logic [rqr_pkg::FUNC_W-1:0] op;
    logic [rqr_pkg::ID_W-1:0] sel_id;

    // empty queue cases and the unused code
    add_word(rqr_pkg::FUNC_DEQ, 16'hFFFF, 16'hFFFF);
    add_word(rqr_pkg::FUNC_REM, 16'hFFFF, 16'h0000);
    add_word(FUNC_NOP, 16'hFFFF, 16'hFFFF);
    // fill to the top with duplicate ids, then enqueue once more, remove and dequeue
    add_word(rqr_pkg::FUNC_ENQ, 16'h0000, 16'hFFFF);
    add_word(rqr_pkg::FUNC_ENQ, 16'hFFFF, 16'h0000);
    for (int k = 2; k < rqr_pkg::DEPTH; k++) begin
      add_word(rqr_pkg::FUNC_ENQ, 16'($urandom), 16'(k % 4 + 1));
    end
    add_word(rqr_pkg::FUNC_ENQ, 16'h1234, 16'h1234);
    add_word(rqr_pkg::FUNC_REM, 16'h0000, 16'd3);
    add_word(rqr_pkg::FUNC_REM, 16'h0000, 16'h5555);
    add_word(rqr_pkg::FUNC_REM, 16'h0000, 16'h0000);
    add_word(rqr_pkg::FUNC_DEQ, 16'h0000, 16'h0000);
    add_word(FUNC_NOP, 16'hA5A5, 16'h5A5A);
    add_pause();

    for (int n = 0; n < RANDOM_OPS; n++) begin
      fill_phase = ((n / 40) % 2) == 0;
      roll = $urandom_range(99);
      if (n % 250 == 249) add_pause();
      if (roll < 5) begin
        op = FUNC_NOP;
      end else if (roll < (fill_phase ? 70 : 30)) begin
        op = rqr_pkg::FUNC_ENQ;
      end else if (roll < (fill_phase ? 85 : 65)) begin
        op = rqr_pkg::FUNC_DEQ;
      end else begin
        op = rqr_pkg::FUNC_REM;
      end
      sel_id = ($urandom_range(99) < 85) ? 16'($urandom_range(7)) : 16'($urandom);
      add_word(op, 16'($urandom), sel_id);
    end

    @(posedge rst_n);
    while (words_sent != total_words || results_seen != total_words) @(posedge clk);
    repeat (5) @(posedge clk);
    if (awaited_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
    end
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
